>>> sv/assert_macros.svh
// assertion macros used by the top-level unit
// every property is sampled on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BLSPH_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BLSPH_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/blsph_pkg.sv
`timescale 1ns / 1ps

package blsph_pkg;

    // q1.15 full scale
    localparam logic [15:0] ONE_Q15    = 16'h8000;
    // q0.16 full scale, the sum of both smoothing weights
    localparam logic [16:0] WEIGHT_ONE = 17'h10000;
    // rounding term of the smoothing sum
    localparam logic [34:0] ROUND_HALF = 35'h0_0000_8000;
    // quotient bits after the leading one
    localparam logic [3:0]  DIV_STEPS  = 4'd15;

    localparam logic        EQ_MODE_RST      = 1'b1;
    localparam logic [7:0]  GRAPH_HEIGHT_RST = 8'd48;
    localparam logic [7:0]  TOP_ROW_RST      = 8'd8;
    localparam logic [7:0]  BOTTOM_ROW_RST   = 8'd55;
    localparam logic [15:0] KEEP_WEIGHT_RST  = 16'd52429;
    localparam logic [15:0] DECAY_STEP_RST   = 16'd164;

    typedef struct packed {
        logic [3:0]  band;
        logic [17:0] level;
    } in_item_t;

    typedef struct packed {
        logic [3:0] band_out;
        logic [7:0] bar_height;
        logic [7:0] bar_top;
        logic       peak_shown;
        logic [7:0] peak_row;
    } out_item_t;

    // one word per band in the state memory
    typedef struct packed {
        logic [17:0] smoothed;
        logic [15:0] peak;
        logic [15:0] decay;
    } band_entry_t;

    typedef enum logic [2:0] {
        CFG_EQ_MODE      = 3'd0,
        CFG_GRAPH_HEIGHT = 3'd1,
        CFG_TOP_ROW      = 3'd2,
        CFG_BOTTOM_ROW   = 3'd3,
        CFG_KEEP_WEIGHT  = 3'd4,
        CFG_DECAY_STEP   = 3'd5
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_MUL_OLD,
        S_MUL_NEW,
        S_SUM,
        S_HEIGHT,
        S_DIV_GO,
        S_DIV,
        S_DECAY,
        S_SQUARE,
        S_SUB,
        S_PIX,
        S_WRITE
    } state_t;

    // pixel count to screen row, clamped up to top then down to bottom
    function automatic logic [7:0] row_of(input logic [7:0] bottom, input logic [7:0] top,
                                          input logic [8:0] pixels);
        logic signed [9:0] r;
        r = $signed({2'b00, bottom}) - $signed({1'b0, pixels});
        if (r < $signed({2'b00, top}))
        begin
            r = $signed({2'b00, top});
        end
        if (r > $signed({2'b00, bottom}))
        begin
            r = $signed({2'b00, bottom});
        end
        return r[7:0];
    endfunction

endpackage

>>> sv/blsph_ram.sv
`timescale 1ns / 1ps

module blsph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/blsph_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit a cycle
// quotient = floor(dividend * 32768 / divisor), dividend <= divisor
module blsph_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [7:0]  dividend,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic [15:0] quotient
);

    logic        busy_reg;
    logic        done_reg;
    logic        zero_reg;
    logic [3:0]  cnt_reg;
    logic [7:0]  div_reg;
    logic [7:0]  rem_reg;
    logic [15:0] quot_reg;

    logic        lead_one;
    logic [7:0]  rem_first;
    logic [8:0]  rem_shift;
    logic        bit_ge;
    logic [7:0]  rem_next;

    always_comb
    begin
        lead_one  = (dividend >= divisor);
        rem_first = lead_one ? 8'(dividend - divisor) : dividend;
        rem_shift = {rem_reg, 1'b0};
        bit_ge    = (rem_shift >= {1'b0, div_reg});
        rem_next  = bit_ge ? 8'(rem_shift - {1'b0, div_reg}) : rem_shift[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= blsph_pkg::DIV_STEPS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            zero_reg <= (divisor == 8'd0);
            div_reg  <= divisor;
            rem_reg  <= rem_first;
            quot_reg <= {15'd0, lead_one};
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[14:0], bit_ge};
        end
    end

    assign done     = done_reg;
    // zero graph height gives a zero quotient
    assign quotient = zero_reg ? 16'd0 : quot_reg;

endmodule

>>> sv/band_level_smoothing_peak_hold_unit.sv
`timescale 1ns / 1ps

// channel   direction  handshake                   payload
// item      in         item_valid / item_stall     blsph_pkg::in_item_t (band, level)
// result    out        result_valid / result_stall blsph_pkg::out_item_t
// cfg       in         cfg_valid / cfg_ready       cfg_index (3 bit), cfg_data (16 bit)
//
// one item at a time: a new item is taken only once the last has left write-back;
// on the way the sequencer starts a serial division of the bar height by graph_height
// the next item is taken while a finished result still waits in the output register
// reset clears the config registers and the per-band valid bits; an entry not yet
// written reads as zero, so no clearing pass is needed
// a stalled result holds the sequencer in write-back only when a second result is ready

`include "assert_macros.svh"

module band_level_smoothing_peak_hold_unit #(
    parameter int NUM_BANDS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 item_valid,
    output logic                 item_stall,
    input  blsph_pkg::in_item_t  item,

    output logic                 result_valid,
    input  logic                 result_stall,
    output blsph_pkg::out_item_t result,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    localparam int BAND_AW   = $clog2(NUM_BANDS);
    localparam int SLOTS     = 1 << BAND_AW;
    localparam int ENTRY_W   = $bits(blsph_pkg::band_entry_t);

    // configuration registers
    logic        eq_mode_reg;
    logic [7:0]  graph_height_reg;
    logic [7:0]  top_row_reg;
    logic [7:0]  bottom_row_reg;
    logic [15:0] keep_weight_reg;
    logic [15:0] decay_step_reg;

    // sequencer
    blsph_pkg::state_t state_reg;
    blsph_pkg::state_t state_next;

    // per-band written flags, cleared at reset
    logic [SLOTS-1:0] valid_reg;

    // item registers
    logic [3:0]         band_reg;
    logic [17:0]        level_reg;
    logic [BAND_AW-1:0] addr_reg;
    logic               track_reg;
    logic               rd_valid_reg;

    // working registers
    logic [17:0] s_reg;
    logic [15:0] pk_reg;
    logic [15:0] d_reg;
    logic [34:0] prod_reg;
    logic [33:0] acc_reg;
    logic [15:0] v_reg;
    logic [7:0]  height_reg;
    logic [15:0] norm_reg;
    logic        rise_reg;

    // output register
    blsph_pkg::out_item_t result_reg;
    logic                 result_valid_reg;

    // combinational
    logic                   accept;
    logic [BAND_AW+3:0]     band_ext;
    logic                   in_range;
    logic [BAND_AW-1:0]     band_addr;
    logic                   ram_re;
    logic                   ram_we;
    logic [ENTRY_W-1:0]     ram_rdata;
    blsph_pkg::band_entry_t entry;
    blsph_pkg::band_entry_t wr_entry;
    logic                   div_start;
    logic                   div_done;
    logic [15:0]            div_quot;
    logic                   out_busy;
    logic                   load_result;
    logic [17:0]            mul_a;
    logic [16:0]            mul_b;
    logic [34:0]            mul_p;
    logic [16:0]            new_weight;
    logic [34:0]            smooth_sum;
    logic [17:0]            s_new;
    logic [17:0]            v_pick;
    logic [16:0]            d_sum;
    logic [15:0]            d_sat;
    logic [15:0]            sq;
    logic [16:0]            pk_diff;
    logic [15:0]            pk_fall;
    logic                   shown;
    blsph_pkg::out_item_t   result_new;

    assign cfg_ready    = 1'b1;
    assign item_stall   = (state_reg != blsph_pkg::S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign out_busy     = result_valid_reg && result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // band range check at any NUM_BANDS
    assign band_ext  = {{BAND_AW{1'b0}}, item.band};
    assign in_range  = (band_ext < (BAND_AW + 4)'(NUM_BANDS));
    assign band_addr = band_ext[BAND_AW-1:0];

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eq_mode_reg      <= blsph_pkg::EQ_MODE_RST;
            graph_height_reg <= blsph_pkg::GRAPH_HEIGHT_RST;
            top_row_reg      <= blsph_pkg::TOP_ROW_RST;
            bottom_row_reg   <= blsph_pkg::BOTTOM_ROW_RST;
            keep_weight_reg  <= blsph_pkg::KEEP_WEIGHT_RST;
            decay_step_reg   <= blsph_pkg::DECAY_STEP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                blsph_pkg::CFG_EQ_MODE:      eq_mode_reg      <= cfg_data[0];
                blsph_pkg::CFG_GRAPH_HEIGHT: graph_height_reg <= cfg_data[7:0];
                blsph_pkg::CFG_TOP_ROW:      top_row_reg      <= cfg_data[7:0];
                blsph_pkg::CFG_BOTTOM_ROW:   bottom_row_reg   <= cfg_data[7:0];
                blsph_pkg::CFG_KEEP_WEIGHT:  keep_weight_reg  <= cfg_data;
                blsph_pkg::CFG_DECAY_STEP:   decay_step_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // band state memory, at most one read and one write-back per item
    blsph_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_BANDS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (band_addr),
        .rdata (ram_rdata)
    );

    // never-written bands read as zero
    assign entry    = rd_valid_reg ? blsph_pkg::band_entry_t'(ram_rdata) : '0;
    assign wr_entry = '{smoothed: s_reg, peak: pk_reg, decay: d_reg};

    blsph_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (height_reg),
        .divisor  (graph_height_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= blsph_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and control
    always_comb
    begin
        state_next  = state_reg;
        ram_re      = 1'b0;
        ram_we      = 1'b0;
        div_start   = 1'b0;
        load_result = 1'b0;
        case (state_reg)
            blsph_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    ram_re     = eq_mode_reg && in_range;
                    state_next = blsph_pkg::S_READ;
                end
            end
            blsph_pkg::S_READ:    state_next = blsph_pkg::S_MUL_OLD;
            blsph_pkg::S_MUL_OLD: state_next = blsph_pkg::S_MUL_NEW;
            blsph_pkg::S_MUL_NEW: state_next = blsph_pkg::S_SUM;
            blsph_pkg::S_SUM:     state_next = blsph_pkg::S_HEIGHT;
            blsph_pkg::S_HEIGHT:  state_next = blsph_pkg::S_DIV_GO;
            blsph_pkg::S_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = blsph_pkg::S_DIV;
            end
            blsph_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = blsph_pkg::S_DECAY;
                end
            end
            blsph_pkg::S_DECAY:   state_next = blsph_pkg::S_SQUARE;
            blsph_pkg::S_SQUARE:  state_next = blsph_pkg::S_SUB;
            blsph_pkg::S_SUB:     state_next = blsph_pkg::S_PIX;
            blsph_pkg::S_PIX:     state_next = blsph_pkg::S_WRITE;
            blsph_pkg::S_WRITE:
            begin
                if (!out_busy)
                begin
                    ram_we      = track_reg;
                    load_result = 1'b1;
                    state_next  = blsph_pkg::S_IDLE;
                end
            end
            default: state_next = blsph_pkg::S_IDLE;
        endcase
    end

    // shared multiplier operands, product is registered
    assign new_weight = blsph_pkg::WEIGHT_ONE - {1'b0, keep_weight_reg};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            blsph_pkg::S_MUL_OLD:
            begin
                mul_a = s_reg;
                mul_b = {1'b0, keep_weight_reg};
            end
            blsph_pkg::S_MUL_NEW:
            begin
                mul_a = level_reg;
                mul_b = new_weight;
            end
            blsph_pkg::S_HEIGHT:
            begin
                mul_a = {2'b00, v_reg};
                mul_b = {9'd0, graph_height_reg};
            end
            blsph_pkg::S_SQUARE:
            begin
                mul_a = {2'b00, d_reg};
                mul_b = {1'b0, d_reg};
            end
            blsph_pkg::S_PIX:
            begin
                mul_a = {2'b00, pk_reg};
                mul_b = {9'd0, graph_height_reg};
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    // datapath helpers
    always_comb
    begin
        // rounded smoothing sum, kept to 18 bits
        smooth_sum = {1'b0, acc_reg} + prod_reg + blsph_pkg::ROUND_HALF;
        s_new      = smooth_sum[33:16];
        v_pick     = track_reg ? s_new : level_reg;

        // decay term grows and saturates at one
        d_sum = {1'b0, d_reg} + {1'b0, decay_step_reg};
        d_sat = (d_sum > {1'b0, blsph_pkg::ONE_Q15}) ? blsph_pkg::ONE_Q15 : d_sum[15:0];

        // peak falls by the squared decay but not below the current height
        sq      = prod_reg[30:15];
        pk_diff = {1'b0, pk_reg} - {1'b0, sq};
        if (pk_diff[16] || (pk_diff[15:0] < norm_reg))
        begin
            pk_fall = norm_reg;
        end
        else
        begin
            pk_fall = pk_diff[15:0];
        end

        shown = track_reg && (pk_reg != 16'd0);

        result_new.band_out   = band_reg;
        result_new.bar_height = height_reg;
        result_new.bar_top    = blsph_pkg::row_of(bottom_row_reg, top_row_reg,
                                                  {1'b0, height_reg});
        result_new.peak_shown = shown;
        result_new.peak_row   = shown ? blsph_pkg::row_of(bottom_row_reg, top_row_reg,
                                                          {1'b0, prod_reg[22:15]}) : 8'd0;
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            blsph_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    band_reg  <= item.band;
                    level_reg <= item.level;
                    addr_reg  <= band_addr;
                    track_reg <= eq_mode_reg && in_range;
                end
            end
            blsph_pkg::S_READ:
            begin
                s_reg  <= entry.smoothed;
                pk_reg <= entry.peak;
                d_reg  <= entry.decay;
            end
            blsph_pkg::S_MUL_OLD:
            begin
                prod_reg <= mul_p;
            end
            blsph_pkg::S_MUL_NEW:
            begin
                acc_reg  <= prod_reg[33:0];
                prod_reg <= mul_p;
            end
            blsph_pkg::S_SUM:
            begin
                s_reg <= s_new;
                v_reg <= (v_pick > {2'b00, blsph_pkg::ONE_Q15}) ? blsph_pkg::ONE_Q15
                                                                : v_pick[15:0];
            end
            blsph_pkg::S_HEIGHT:
            begin
                // v <= one, so the height never passes graph_height
                height_reg <= mul_p[22:15];
            end
            blsph_pkg::S_DECAY:
            begin
                norm_reg <= div_quot;
                rise_reg <= (div_quot > pk_reg);
                d_reg    <= (div_quot > pk_reg) ? 16'd0 : d_sat;
            end
            blsph_pkg::S_SQUARE:
            begin
                prod_reg <= mul_p;
            end
            blsph_pkg::S_SUB:
            begin
                pk_reg <= rise_reg ? norm_reg : pk_fall;
            end
            blsph_pkg::S_PIX:
            begin
                prod_reg <= mul_p;
            end
            blsph_pkg::S_WRITE:
            begin
                if (load_result)
                begin
                    result_reg <= result_new;
                end
            end
            default: ;
        endcase
    end

    // read flag is registered alongside the memory read, so it lines up with the read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rd_valid_reg <= ram_re && valid_reg[band_addr];
        end
    end

    // written flags and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (ram_we)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
            if (load_result)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // checks
    `BLSPH_ASSERT_IMP(a_div_done_waiting, div_done, state_reg == blsph_pkg::S_DIV, "divider finished outside its wait state")
    `BLSPH_ASSERT_IMP(a_norm_in_range, state_reg == blsph_pkg::S_DECAY, div_quot <= blsph_pkg::ONE_Q15, "normalized height above one")
    `BLSPH_ASSERT_IMP(a_decay_in_range, state_reg == blsph_pkg::S_SQUARE, d_reg <= blsph_pkg::ONE_Q15, "decay term above one")
    `BLSPH_ASSERT_NXT(a_transfer_reads, accept, state_reg == blsph_pkg::S_READ && item_stall, "transfer did not start a memory read")

endmodule
